// File: hdl/tnpe_pkg.sv
`timescale 1ns / 1ps
package tnpe_pkg;

   localparam int unsigned MaxEncodedBytes = 256;
   localparam int unsigned MaxDimensions   = 3;
   localparam int unsigned PosWidth        = 9;

   localparam logic [1:0] KIND_CHAR   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_FORMAT  = 2'd1;
   localparam logic [1:0] ERR_TOOLONG = 2'd2;

   localparam logic [7:0] SEG_SYMBOL = 8'h91;
   localparam logic [7:0] SEG_IDX8   = 8'h28;
   localparam logic [7:0] SEG_IDX16  = 8'h29;
   localparam logic [7:0] SEG_IDX32  = 8'h2A;

   localparam int unsigned QueueDepth = 2;

   // one request as queued by the front end
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [7:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic       valid;
      logic       ready;
   } link_type;

   typedef enum logic [9:0] {
      PH_START    = 10'b00_0000_0001,
      PH_SYM      = 10'b00_0000_0010,
      PH_AFTER    = 10'b00_0000_0100,
      PH_DOT      = 10'b00_0000_1000,
      PH_BIT_PRE  = 10'b00_0001_0000,
      PH_BIT_NUM  = 10'b00_0010_0000,
      PH_IDX_PRE  = 10'b00_0100_0000,
      PH_IDX_NUM  = 10'b00_1000_0000,
      PH_IDX_POST = 10'b01_0000_0000,
      PH_ENDED    = 10'b10_0000_0000
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_WRITE = 3'b010,
      BK_OUT   = 3'b100
   } back_state_type;

endpackage

// File: hdl/tnpe_front.sv
`timescale 1ns / 1ps
// Accepts requests and holds them in a short queue for the back end.
module tnpe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tnpe_pkg::req_item_type in_item,
   output logic                  q_valid,
   input  logic                  q_ready,
   output tnpe_pkg::req_item_type q_item
);

   tnpe_pkg::req_item_type slot_ff [tnpe_pkg::QueueDepth];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic       push, pop;

   assign in_ready = (count_ff != 2'(tnpe_pkg::QueueDepth));
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // pointer and fill bookkeeping
   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(tnpe_pkg::QueueDepth))
      else $error("queue overfilled");
   no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'(tnpe_pkg::QueueDepth)) |-> !push)
      else $error("push into full queue");
   pop_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("pop miscounted");

endmodule

// File: hdl/tnpe_back.sv
`timescale 1ns / 1ps
// Parses one request, then writes its encoded bytes one per cycle, then
// presents the result in an output register.
module tnpe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  tnpe_pkg::req_item_type q_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [1:0]             out_status,
   output logic [7:0]             out_byte,
   output logic [8:0]             out_length,
   output logic                   out_is_bit,
   output logic [7:0]             out_bit_number
);

   typedef logic [tnpe_pkg::PosWidth-1:0] pos_type;

   logic [7:0] mem [tnpe_pkg::MaxEncodedBytes];

   tnpe_pkg::back_state_type state_ff, state_in;
   tnpe_pkg::phase_type      phase_ff, phase_in;
   pos_type    wpos_ff, wpos_in, lenpos_ff, lenpos_in;
   logic [7:0] segcnt_ff, segcnt_in;
   logic [31:0] acc_ff, acc_in;
   logic       digits_ff, digits_in, neg_ff, neg_in;
   logic [1:0] dim_ff, dim_in, err_ff, err_in;
   logic       bflag_ff, bflag_in;
   logic [7:0] bval_ff, bval_in;

   // write list produced by the parse step, drained one byte a cycle
   logic [7:0] wbyte_ff [6];
   logic [7:0] wbyte_in [6];
   pos_type    wbase_ff, wbase_in;
   logic [2:0] wcnt_ff, wcnt_in, widx_ff, widx_in;
   logic       lenw_ff, lenw_in;
   pos_type    lenwpos_ff, lenwpos_in;
   logic [7:0] lenwval_ff, lenwval_in;
   logic       zw_ff, zw_in;
   logic [7:0] zval_ff, zval_in;

   logic       rd_ff, rd_in;
   logic [7:0] rd_data_ff;
   logic [7:0] q_item_rd_ff;

   logic [1:0] o_status_ff;
   logic [8:0] o_len_ff;
   logic       o_bit_ff;
   logic [7:0] o_bitn_ff;

   logic [7:0] c;
   logic       isdig, isalpha, isspace, symstart, symcont;
   logic [3:0] dval;
   logic [35:0] acc_mul;
   logic [31:0] acc_next;

   assign c        = q_item.char_code;
   assign isdig    = (c >= 8'h30) && (c <= 8'h39);
   assign isalpha  = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   assign isspace  = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
   assign symstart = isalpha || (c == 8'h3A) || (c == 8'h5F) || (c == 8'h40);
   assign symcont  = isalpha || isdig || (c == 8'h3A) || (c == 8'h5F);
   assign dval     = c[3:0] - 4'd0;
   // acc*10 + d with saturation: shifts and adds, no multiplier
   assign acc_mul  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {32'd0, dval};
   assign acc_next = (acc_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_mul[31:0];

   assign q_ready        = (state_ff == tnpe_pkg::BK_IDLE);
   assign out_valid      = (state_ff == tnpe_pkg::BK_OUT);
   assign out_status     = o_status_ff;
   assign out_byte       = rd_ff ? rd_data_ff : 8'd0;
   assign out_length     = o_len_ff;
   assign out_is_bit     = o_bit_ff;
   assign out_bit_number = o_bitn_ff;

   // parse step: one request updates the parser and queues up to six bytes
   always_comb begin
      logic [7:0] wb [6];
      logic [2:0] n;
      logic       e;
      logic [31:0] v;
      logic        do_num;
      logic [1:0]  kind;
      phase_in   = phase_ff;
      wpos_in    = wpos_ff;
      lenpos_in  = lenpos_ff;
      segcnt_in  = segcnt_ff;
      acc_in     = acc_ff;
      digits_in  = digits_ff;
      neg_in     = neg_ff;
      dim_in     = dim_ff;
      err_in     = err_ff;
      bflag_in   = bflag_ff;
      bval_in    = bval_ff;
      lenw_in    = 1'b0;
      lenwpos_in = lenpos_ff;
      lenwval_in = segcnt_ff;
      zw_in      = 1'b0;
      zval_in    = 8'd0;
      rd_in      = 1'b0;
      for (int i = 0; i < 6; i++) begin
         wb[i] = 8'd0;
      end
      n      = 3'd0;
      e      = 1'b0;
      v      = acc_ff;
      do_num = 1'b0;
      kind   = q_item.kind;
      case (kind)
         tnpe_pkg::KIND_CHAR: begin
            if (phase_ff == tnpe_pkg::PH_ENDED) begin
               phase_in  = tnpe_pkg::PH_START;
               wpos_in   = pos_type'(1);
               lenpos_in = '0;
               segcnt_in = 8'd0;
               acc_in    = 32'd0;
               digits_in = 1'b0;
               neg_in    = 1'b0;
               dim_in    = 2'd0;
               bflag_in  = 1'b0;
               bval_in   = 8'd0;
               err_in    = tnpe_pkg::ERR_NONE;
               zw_in     = 1'b1;
            end
            if ((phase_ff == tnpe_pkg::PH_ENDED) || (err_ff == tnpe_pkg::ERR_NONE)) begin
               case (phase_ff)
                  tnpe_pkg::PH_START, tnpe_pkg::PH_ENDED: begin
                     if (!symstart) begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end else begin
                        // fresh name always has room
                        lenpos_in = pos_type'(2);
                        wb[0] = tnpe_pkg::SEG_SYMBOL; wb[1] = 8'd1; wb[2] = c;
                        n = 3'd3;
                        segcnt_in = 8'd1;
                        phase_in = tnpe_pkg::PH_SYM;
                     end
                  end
                  tnpe_pkg::PH_SYM: begin
                     if (symcont) begin
                        if ({1'b0, wpos_ff} + 10'd1 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                           err_in = tnpe_pkg::ERR_TOOLONG;
                        end else begin
                           wb[0] = c; n = 3'd1;
                           segcnt_in  = segcnt_ff + 8'd1;
                           lenw_in    = 1'b1;
                           lenwval_in = segcnt_ff + 8'd1;
                        end
                     end else begin
                        if (segcnt_ff[0]) begin
                           if ({1'b0, wpos_ff} + 10'd1 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                              err_in = tnpe_pkg::ERR_TOOLONG; e = 1'b1;
                           end else begin
                              wb[0] = 8'd0; n = 3'd1;
                           end
                        end
                        if (!e) begin
                           if ((c != 8'h2E) && (c != 8'h5B)) begin
                              err_in = tnpe_pkg::ERR_FORMAT;
                           end else if ({1'b0, wpos_ff} + {7'd0, n} >=
                                        10'(tnpe_pkg::MaxEncodedBytes)) begin
                              err_in = tnpe_pkg::ERR_TOOLONG;
                           end else if (c == 8'h2E) begin
                              phase_in = tnpe_pkg::PH_DOT;
                           end else begin
                              dim_in = 2'd0; acc_in = 32'd0; digits_in = 1'b0; neg_in = 1'b0;
                              phase_in = tnpe_pkg::PH_IDX_PRE;
                           end
                        end
                     end
                  end
                  tnpe_pkg::PH_AFTER: begin
                     if ((c != 8'h2E) && (c != 8'h5B)) begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end else if ({1'b0, wpos_ff} >= 10'(tnpe_pkg::MaxEncodedBytes)) begin
                        err_in = tnpe_pkg::ERR_TOOLONG;
                     end else if (c == 8'h2E) begin
                        phase_in = tnpe_pkg::PH_DOT;
                     end else begin
                        dim_in = 2'd0; acc_in = 32'd0; digits_in = 1'b0; neg_in = 1'b0;
                        phase_in = tnpe_pkg::PH_IDX_PRE;
                     end
                  end
                  tnpe_pkg::PH_DOT: begin
                     if (symstart) begin
                        if ({1'b0, wpos_ff} + 10'd4 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                           err_in = tnpe_pkg::ERR_TOOLONG;
                        end else begin
                           lenpos_in = wpos_ff + pos_type'(1);
                           wb[0] = tnpe_pkg::SEG_SYMBOL; wb[1] = 8'd1; wb[2] = c;
                           n = 3'd3; segcnt_in = 8'd1;
                           phase_in = tnpe_pkg::PH_SYM;
                        end
                     end else begin
                        acc_in = 32'd0; digits_in = 1'b0; neg_in = 1'b0;
                        phase_in = tnpe_pkg::PH_BIT_PRE;
                        if (isspace) begin
                        end else if ((c == 8'h2B) || (c == 8'h2D)) begin
                           neg_in = (c == 8'h2D); phase_in = tnpe_pkg::PH_BIT_NUM;
                        end else if (isdig) begin
                           acc_in = {28'd0, dval}; digits_in = 1'b1;
                           phase_in = tnpe_pkg::PH_BIT_NUM;
                        end else begin
                           err_in = tnpe_pkg::ERR_FORMAT;
                        end
                     end
                  end
                  tnpe_pkg::PH_BIT_PRE, tnpe_pkg::PH_IDX_PRE: begin
                     if (isspace) begin
                     end else if ((c == 8'h2B) || (c == 8'h2D)) begin
                        neg_in = (c == 8'h2D);
                        phase_in = (phase_ff == tnpe_pkg::PH_BIT_PRE) ?
                                   tnpe_pkg::PH_BIT_NUM : tnpe_pkg::PH_IDX_NUM;
                     end else if (isdig) begin
                        acc_in = acc_next; digits_in = 1'b1;
                        phase_in = (phase_ff == tnpe_pkg::PH_BIT_PRE) ?
                                   tnpe_pkg::PH_BIT_NUM : tnpe_pkg::PH_IDX_NUM;
                     end else begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end
                  end
                  tnpe_pkg::PH_BIT_NUM: begin
                     if (isdig) begin
                        acc_in = acc_next; digits_in = 1'b1;
                     end else begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end
                  end
                  tnpe_pkg::PH_IDX_NUM: begin
                     if (isdig) begin
                        acc_in = acc_next; digits_in = 1'b1;
                     end else if (!digits_ff) begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end else begin
                        do_num = 1'b1;
                     end
                  end
                  tnpe_pkg::PH_IDX_POST: begin
                     if (c == 8'h20) begin
                     end else if ((c == 8'h2C) && (dim_ff < 2'(tnpe_pkg::MaxDimensions))) begin
                        acc_in = 32'd0; digits_in = 1'b0; neg_in = 1'b0;
                        phase_in = tnpe_pkg::PH_IDX_PRE;
                     end else if (c == 8'h5D) begin
                        phase_in = tnpe_pkg::PH_AFTER;
                     end else begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end
                  end
                  default: err_in = tnpe_pkg::ERR_FORMAT;
               endcase
               // index emission then post-index handling of the same char
               if (do_num) begin
                  if (neg_ff && (v != 32'd0)) begin
                     err_in = tnpe_pkg::ERR_FORMAT; e = 1'b1;
                  end else if (v > 32'h0000_FFFF) begin
                     if ({1'b0, wpos_ff} + 10'd6 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                        err_in = tnpe_pkg::ERR_TOOLONG; e = 1'b1;
                     end else begin
                        wb[0] = tnpe_pkg::SEG_IDX32; wb[1] = 8'd0;
                        wb[2] = v[7:0]; wb[3] = v[15:8]; wb[4] = v[23:16]; wb[5] = v[31:24];
                        n = 3'd6;
                     end
                  end else if (v > 32'h0000_00FF) begin
                     if ({1'b0, wpos_ff} + 10'd4 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                        err_in = tnpe_pkg::ERR_TOOLONG; e = 1'b1;
                     end else begin
                        wb[0] = tnpe_pkg::SEG_IDX16; wb[1] = 8'd0;
                        wb[2] = v[7:0]; wb[3] = v[15:8];
                        n = 3'd4;
                     end
                  end else begin
                     if ({1'b0, wpos_ff} + 10'd2 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                        err_in = tnpe_pkg::ERR_TOOLONG; e = 1'b1;
                     end else begin
                        wb[0] = tnpe_pkg::SEG_IDX8; wb[1] = v[7:0];
                        n = 3'd2;
                     end
                  end
                  if (!e) begin
                     dim_in = dim_ff + 2'd1;
                     phase_in = tnpe_pkg::PH_IDX_POST;
                     if (c == 8'h20) begin
                     end else if ((c == 8'h2C) &&
                                  ((dim_ff + 2'd1) < 2'(tnpe_pkg::MaxDimensions))) begin
                        acc_in = 32'd0; digits_in = 1'b0; neg_in = 1'b0;
                        phase_in = tnpe_pkg::PH_IDX_PRE;
                     end else if (c == 8'h5D) begin
                        phase_in = tnpe_pkg::PH_AFTER;
                     end else begin
                        err_in = tnpe_pkg::ERR_FORMAT;
                     end
                  end
               end
               wpos_in = ((phase_ff == tnpe_pkg::PH_ENDED) ? pos_type'(1) : wpos_ff) +
                         pos_type'(n);
            end
         end
         tnpe_pkg::KIND_END: begin
            if (phase_ff != tnpe_pkg::PH_ENDED) begin
               if (err_ff == tnpe_pkg::ERR_NONE) begin
                  case (phase_ff)
                     tnpe_pkg::PH_SYM: begin
                        if (segcnt_ff[0]) begin
                           if ({1'b0, wpos_ff} + 10'd1 > 10'(tnpe_pkg::MaxEncodedBytes)) begin
                              err_in = tnpe_pkg::ERR_TOOLONG;
                           end else begin
                              wb[0] = 8'd0; n = 3'd1;
                           end
                        end
                     end
                     tnpe_pkg::PH_AFTER: begin
                     end
                     tnpe_pkg::PH_BIT_NUM: begin
                        if (!digits_ff || (neg_ff && (acc_ff != 32'd0)) ||
                            (acc_ff > 32'd255)) begin
                           err_in = tnpe_pkg::ERR_FORMAT;
                        end else begin
                           bflag_in = 1'b1; bval_in = acc_ff[7:0];
                        end
                     end
                     default: err_in = tnpe_pkg::ERR_FORMAT;
                  endcase
                  wpos_in = wpos_ff + pos_type'(n);
                  if (err_in == tnpe_pkg::ERR_NONE) begin
                     zw_in   = 1'b1;
                     zval_in = 8'((wpos_in - pos_type'(1)) >> 1);
                  end
               end
               phase_in = tnpe_pkg::PH_ENDED;
            end
         end
         tnpe_pkg::KIND_READ: begin
            rd_in = 1'b1;
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         wbyte_in[i] = wb[i];
      end
      wcnt_in  = n;
      wbase_in = (kind == tnpe_pkg::KIND_CHAR && phase_ff == tnpe_pkg::PH_ENDED) ?
                 pos_type'(1) : wpos_ff;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      widx_in  = widx_ff;
      case (state_ff)
         tnpe_pkg::BK_IDLE: begin
            if (q_valid) begin
               state_in = tnpe_pkg::BK_WRITE;
               widx_in  = 3'd0;
            end
         end
         tnpe_pkg::BK_WRITE: begin
            if (widx_ff >= wcnt_ff) begin
               state_in = tnpe_pkg::BK_OUT;
            end else begin
               widx_in = widx_ff + 3'd1;
            end
         end
         tnpe_pkg::BK_OUT: begin
            if (out_ready) begin
               state_in = tnpe_pkg::BK_IDLE;
            end
         end
         default: state_in = tnpe_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tnpe_pkg::BK_IDLE;
         phase_ff  <= tnpe_pkg::PH_START;
         wpos_ff   <= pos_type'(1);
         lenpos_ff <= '0;
         segcnt_ff <= 8'd0;
         acc_ff    <= 32'd0;
         digits_ff <= 1'b0;
         neg_ff    <= 1'b0;
         dim_ff    <= 2'd0;
         err_ff    <= tnpe_pkg::ERR_NONE;
         bflag_ff  <= 1'b0;
         bval_ff   <= 8'd0;
         widx_ff   <= 3'd0;
         wcnt_ff   <= 3'd0;
         lenw_ff   <= 1'b0;
         zw_ff     <= 1'b0;
         rd_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         widx_ff  <= widx_in;
         if (q_valid && q_ready) begin
            phase_ff  <= phase_in;
            wpos_ff   <= wpos_in;
            lenpos_ff <= lenpos_in;
            segcnt_ff <= segcnt_in;
            acc_ff    <= acc_in;
            digits_ff <= digits_in;
            neg_ff    <= neg_in;
            dim_ff    <= dim_in;
            err_ff    <= err_in;
            bflag_ff  <= bflag_in;
            bval_ff   <= bval_in;
            wcnt_ff   <= wcnt_in;
            lenw_ff   <= lenw_in;
            zw_ff     <= zw_in;
            rd_ff     <= rd_in;
         end
      end
   end

   // payload of the write list and result
   always_ff @(posedge clock) begin
      if (q_valid && q_ready) begin
         wbyte_ff   <= wbyte_in;
         wbase_ff   <= wbase_in;
         lenwpos_ff <= lenwpos_in;
         lenwval_ff <= lenwval_in;
         zval_ff    <= zval_in;
         o_status_ff <= err_in;
         o_len_ff    <= (err_in != tnpe_pkg::ERR_NONE) ? 9'd0 : wpos_in;
         o_bit_ff    <= bflag_in;
         o_bitn_ff   <= bflag_in ? bval_in : 8'd0;
         q_item_rd_ff <= q_item.read_index;
      end
   end

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      pos_type wa;
      wa = wbase_ff + pos_type'(widx_ff);
      if (state_ff == tnpe_pkg::BK_WRITE) begin
         if (widx_ff < wcnt_ff) begin
            if (!wa[8]) begin
               mem[wa[7:0]] <= wbyte_ff[widx_ff];
            end
         end else if (zw_ff) begin
            mem[8'd0] <= zval_ff;
         end
      end else if (state_ff == tnpe_pkg::BK_OUT && lenw_ff && !lenwpos_ff[8]) begin
         mem[lenwpos_ff[7:0]] <= lenwval_ff;
      end
      if (state_ff == tnpe_pkg::BK_WRITE) begin
         rd_data_ff <= mem[q_item_rd_ff];
      end
   end

   seq_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
   take_only_idle: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |=> (state_ff == tnpe_pkg::BK_WRITE))
      else $error("request not followed by write phase");
   len_zero_on_err: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_status != tnpe_pkg::ERR_NONE) |-> (out_length == 9'd0))
      else $error("length reported with error");
   hold_out: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("result dropped");

endmodule

// File: hdl/tag_name_path_encoder_unit.sv
`timescale 1ns / 1ps
// channel | dir | fields (tdata low bit up)
// req     | in  | tdata: kind[1:0] char_code[9:2] read_index[17:10], pad to 24
// rsp     | out | tdata: status[1:0] byte_value[9:2] encoded_length[18:10]
//         |     |        is_bit[19] bit_number[27:20], pad to 32
// An item is parsed when taken; its encoded bytes (0 to 6) are then written
// in turn into the store (one write port, one registered read port), a last
// step writes the word-count byte and does the store read, then the result shows.
// A two-entry queue lets requests be taken while the back end works.
// Reset is synchronous and active high; the store is not cleared.
// rsp stalls hold the result and back-pressure the queue.
module tag_name_path_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // kind, char_code, read_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // status, byte_value, encoded_length, is_bit, bit_number
);

   tnpe_pkg::req_item_type in_item, q_item;
   logic q_valid, q_ready;
   logic [1:0] st;
   logic [7:0] bv, bn;
   logic [8:0] ln;
   logic       ib;

   assign in_item.kind       = req_tdata[1:0];
   assign in_item.char_code  = req_tdata[9:2];
   assign in_item.read_index = req_tdata[17:10];

   tnpe_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   tnpe_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_status(st), .out_byte(bv), .out_length(ln),
      .out_is_bit(ib), .out_bit_number(bn)
   );

   assign rsp_tdata = {4'd0, bn, ib, ln, bv, st};

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;

   // result fields as packed on rsp_tdata
   typedef struct {
      logic [1:0] status;
      logic [7:0] byte_value;
      logic [8:0] encoded_length;
      logic       is_bit;
      logic [7:0] bit_number;
   } path_result_type;

   // tracks expected results and counts mismatches
   class path_scoreboard;
      path_result_type pending[$];
      int mismatches;
      int reported;

      function void note_request(path_result_type r);
         pending.push_back(r);
      endfunction

      function void check_result(logic [31:0] d);
         path_result_type e;
         logic bad;
         if (pending.size() == 0) begin
            mismatches++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result %h", d);
            end
            return;
         end
         e = pending.pop_front();
         bad = (d[1:0] !== e.status) || (d[9:2] !== e.byte_value)
            || (d[18:10] !== e.encoded_length) || (d[19] !== e.is_bit)
            || (d[27:20] !== e.bit_number);
         if (bad) begin
            mismatches++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: exp st=%0d b=%h len=%0d bit=%0d/%0d got %h",
                        e.status, e.byte_value, e.encoded_length, e.is_bit,
                        e.bit_number, d);
            end
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;

   path_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_req      = 0;
   int hold_cycles   = 0;

   tag_name_path_encoder_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // predictor state
   logic [7:0]  path_store [0:255];
   tnpe_pkg::phase_type phase;
   int unsigned wpos, len_pos, seg_count, accum;
   bit          have_digits, minus, bit_seen;
   int unsigned dims;
   logic [7:0]  bit_val;
   logic [1:0]  err;

   function automatic bit is_digit(int unsigned c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_alpha(int unsigned c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction
   function automatic bit is_space(int unsigned c);
      return c == " " || (c >= 9 && c <= 13);
   endfunction
   function automatic bit sym_first(int unsigned c);
      return is_alpha(c) || c == ":" || c == "_" || c == "@";
   endfunction
   function automatic bit sym_next(int unsigned c);
      return is_alpha(c) || is_digit(c) || c == ":" || c == "_";
   endfunction

   function void set_err(logic [1:0] code);
      if (err == tnpe_pkg::ERR_NONE) err = code;
   endfunction

   function bit has_room(int unsigned n);
      if (wpos + n > tnpe_pkg::MaxEncodedBytes) begin
         set_err(tnpe_pkg::ERR_TOOLONG);
         return 0;
      end
      return 1;
   endfunction

   function void store_byte(logic [7:0] b);
      if (wpos < tnpe_pkg::MaxEncodedBytes) path_store[wpos] = b;
      wpos++;
   endfunction

   function void clear_num();
      accum = 0; have_digits = 0; minus = 0;
   endfunction

   function void push_digit(int unsigned c);
      int unsigned d;
      d = c - "0";
      if (accum > (32'hFFFF_FFFF - d) / 10) accum = 32'hFFFF_FFFF;
      else accum = accum * 10 + d;
      have_digits = 1;
   endfunction

   function void start_name();
      phase = tnpe_pkg::PH_START; wpos = 1; path_store[0] = 8'd0;
      len_pos = 0; seg_count = 0; clear_num(); dims = 0;
      bit_seen = 0; bit_val = 0; err = tnpe_pkg::ERR_NONE;
   endfunction

   function void open_symbol(int unsigned c);
      if (!has_room(4)) return;
      len_pos = wpos + 1;
      store_byte(tnpe_pkg::SEG_SYMBOL); store_byte(8'd1); store_byte(c[7:0]);
      seg_count = 1; phase = tnpe_pkg::PH_SYM;
   endfunction

   function void pad_symbol();
      if (seg_count[0] && has_room(1)) store_byte(8'd0);
   endfunction

   function void write_index();
      if (minus && accum != 0) begin
         set_err(tnpe_pkg::ERR_FORMAT);
         return;
      end
      if (accum > 32'hFFFF) begin
         if (!has_room(6)) return;
         store_byte(tnpe_pkg::SEG_IDX32); store_byte(8'd0);
         store_byte(accum[7:0]); store_byte(accum[15:8]);
         store_byte(accum[23:16]); store_byte(accum[31:24]);
      end else if (accum > 255) begin
         if (!has_room(4)) return;
         store_byte(tnpe_pkg::SEG_IDX16); store_byte(8'd0);
         store_byte(accum[7:0]); store_byte(accum[15:8]);
      end else begin
         if (!has_room(2)) return;
         store_byte(tnpe_pkg::SEG_IDX8); store_byte(accum[7:0]);
      end
      dims = (dims + 1) & 3;
   endfunction

   function void segment_sep(int unsigned c);
      if (c != "." && c != "[") begin
         set_err(tnpe_pkg::ERR_FORMAT);
         return;
      end
      if (wpos >= tnpe_pkg::MaxEncodedBytes) begin
         set_err(tnpe_pkg::ERR_TOOLONG);
         return;
      end
      if (c == ".") phase = tnpe_pkg::PH_DOT;
      else begin
         dims = 0; clear_num(); phase = tnpe_pkg::PH_IDX_PRE;
      end
   endfunction

   function void num_lead(int unsigned c, tnpe_pkg::phase_type nxt);
      if (is_space(c)) return;
      if (c == "+" || c == "-") begin
         minus = (c == "-"); phase = nxt;
      end else if (is_digit(c)) begin
         push_digit(c); phase = nxt;
      end else set_err(tnpe_pkg::ERR_FORMAT);
   endfunction

   function void index_tail(int unsigned c);
      if (c == " ") return;
      if (c == "," && dims < tnpe_pkg::MaxDimensions) begin
         clear_num(); phase = tnpe_pkg::PH_IDX_PRE;
      end else if (c == "]") phase = tnpe_pkg::PH_AFTER;
      else set_err(tnpe_pkg::ERR_FORMAT);
   endfunction

   function void parse_char(int unsigned c);
      case (phase)
         tnpe_pkg::PH_START: begin
            if (sym_first(c)) open_symbol(c); else set_err(tnpe_pkg::ERR_FORMAT);
         end
         tnpe_pkg::PH_SYM: begin
            if (sym_next(c)) begin
               if (has_room(1)) begin
                  store_byte(c[7:0]);
                  seg_count = (seg_count + 1) & 8'hFF;
                  if (len_pos < tnpe_pkg::MaxEncodedBytes)
                     path_store[len_pos] = seg_count[7:0];
               end
            end else begin
               pad_symbol();
               if (err == tnpe_pkg::ERR_NONE) segment_sep(c);
            end
         end
         tnpe_pkg::PH_AFTER: segment_sep(c);
         tnpe_pkg::PH_DOT: begin
            if (sym_first(c)) open_symbol(c);
            else begin
               clear_num(); phase = tnpe_pkg::PH_BIT_PRE;
               num_lead(c, tnpe_pkg::PH_BIT_NUM);
            end
         end
         tnpe_pkg::PH_BIT_PRE: num_lead(c, tnpe_pkg::PH_BIT_NUM);
         tnpe_pkg::PH_BIT_NUM: begin
            if (is_digit(c)) push_digit(c); else set_err(tnpe_pkg::ERR_FORMAT);
         end
         tnpe_pkg::PH_IDX_PRE: num_lead(c, tnpe_pkg::PH_IDX_NUM);
         tnpe_pkg::PH_IDX_NUM: begin
            if (is_digit(c)) push_digit(c);
            else if (!have_digits) set_err(tnpe_pkg::ERR_FORMAT);
            else begin
               write_index();
               if (err == tnpe_pkg::ERR_NONE) begin
                  phase = tnpe_pkg::PH_IDX_POST; index_tail(c);
               end
            end
         end
         tnpe_pkg::PH_IDX_POST: index_tail(c);
         default: set_err(tnpe_pkg::ERR_FORMAT);
      endcase
   endfunction

   function void close_name();
      case (phase)
         tnpe_pkg::PH_SYM: pad_symbol();
         tnpe_pkg::PH_AFTER: ;
         tnpe_pkg::PH_BIT_NUM: begin
            if (!have_digits || (minus && accum != 0) || accum > 255)
               set_err(tnpe_pkg::ERR_FORMAT);
            else begin
               bit_seen = 1; bit_val = accum[7:0];
            end
         end
         default: set_err(tnpe_pkg::ERR_FORMAT);
      endcase
      if (err == tnpe_pkg::ERR_NONE) path_store[0] = 8'((wpos - 1) / 2);
   endfunction

   function path_result_type encode_step(logic [1:0] kind, logic [7:0] ch, logic [7:0] idx);
      path_result_type r;
      logic [7:0] b;
      b = 0;
      if (kind == tnpe_pkg::KIND_CHAR) begin
         if (phase == tnpe_pkg::PH_ENDED) start_name();
         if (err == tnpe_pkg::ERR_NONE) parse_char(ch);
      end else if (kind == tnpe_pkg::KIND_END) begin
         if (phase != tnpe_pkg::PH_ENDED) begin
            if (err == tnpe_pkg::ERR_NONE) close_name();
            phase = tnpe_pkg::PH_ENDED;
         end
      end else if (kind == tnpe_pkg::KIND_READ) begin
         b = path_store[idx];
      end
      r.status = err;
      r.byte_value = b;
      r.encoded_length = (err != tnpe_pkg::ERR_NONE) ? 9'd0 : wpos[8:0];
      r.is_bit = bit_seen;
      r.bit_number = bit_seen ? bit_val : 8'd0;
      return r;
   endfunction

   // offer one request and hold it until taken; valid drops only on idle cycles
   task automatic send_request(logic [1:0] kind, logic [7:0] ch, logic [7:0] idx);
      bit first;
      first = 1;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         if (first) req_tvalid <= 0;
         first = 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {6'd0, idx, ch, kind};
      do @(posedge clock); while (!req_tready);
      board.note_request(encode_step(kind, ch, idx));
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(tnpe_pkg::KIND_CHAR, s[i], $urandom);
   endtask

   // finish a name, then optionally read back each written byte, plus a random one
   task automatic end_and_read(bit read_all);
      int unsigned n;
      send_request(tnpe_pkg::KIND_END, $urandom, $urandom);
      n = (wpos > tnpe_pkg::MaxEncodedBytes) ? tnpe_pkg::MaxEncodedBytes : wpos;
      if (read_all)
         for (int i = 0; i < n; i++) send_request(tnpe_pkg::KIND_READ, $urandom, 8'(i));
      send_request(tnpe_pkg::KIND_READ, $urandom, 8'($urandom_range(n - 1)));
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // random name text, well-formed except that a trailing bit number may exceed 255
   function automatic string rand_name();
      string s;
      string syms;
      string firsts;
      string seconds;
      int parts;
      syms = "ABCXYZabcxyz_:09";
      firsts = "Aa_:@";
      seconds = "bQ_";
      s = $sformatf("%c", firsts[$urandom_range(4)]);
      for (int k = $urandom_range(5); k > 0; k--)
         s = {s, $sformatf("%c", syms[$urandom_range(15)])};
      parts = $urandom_range(3);
      for (int p = 0; p < parts; p++) begin
         if ($urandom_range(1)) begin
            s = {s, ".", $sformatf("%c", seconds[$urandom_range(2)])};
            for (int k = $urandom_range(3); k > 0; k--)
               s = {s, $sformatf("%c", syms[$urandom_range(15)])};
         end else begin
            s = {s, "["};
            for (int d = $urandom_range(2); d >= 0; d--) begin
               case ($urandom_range(3))
                  0: s = {s, $sformatf("%0d", $urandom_range(255))};
                  1: s = {s, $sformatf(" +%0d ", $urandom_range(65535))};
                  2: s = {s, $sformatf("%0d", $urandom)};
                  default: s = {s, $sformatf("\t-0")};
               endcase
               if (d > 0) s = {s, ","};
            end
            s = {s, "]"};
         end
      end
      if ($urandom_range(3) == 0) s = {s, $sformatf(".%0d", $urandom_range(300))};
      return s;
   endfunction

   // receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_req && hold_cycles < 300) begin
         hold_cycles <= hold_cycles + 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
      end
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      string s;
      for (int i = 0; i < 256; i++) path_store[i] = 0;
      start_name();
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed names
      send_text("Tag_1.Sub[0,300,70000].7");
      end_and_read(1);
      send_text("@x:y[ -0 ,+255 ]");
      end_and_read(0);
      send_text("a[4294967296].255"); end_and_read(0);
      send_text("b.256"); end_and_read(0);
      send_text("c.-1"); end_and_read(0);
      send_text("d[1,2,3,4]"); end_and_read(0);
      send_text("e."); end_and_read(0);
      send_request(tnpe_pkg::KIND_END, 0, 0);
      send_request(tnpe_pkg::KIND_END, 0, 0);
      send_request(tnpe_pkg::KIND_CHAR, 8'h00, 0);
      send_request(tnpe_pkg::KIND_CHAR, 8'hFF, 8'hFF);
      send_request(tnpe_pkg::KIND_UNUSED, 8'h80, 8'h55);
      end_and_read(0);
      send_text("f[]"); end_and_read(0);
      send_text("g.3 "); end_and_read(0);
      // overflow: long symbol fills the store
      s = "L";
      for (int i = 0; i < 253; i++) s = {s, "k"};
      send_text(s); end_and_read(0);

      // random phases with different idling
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 45 : 0;
         recv_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 33 : 0;
         if (ph == 1) hold_req = 1;
         for (int n = 0; n < 2; n++) begin
            s = rand_name();
            if ($urandom_range(5) == 0) s[$urandom_range(s.len() - 1)] = $urandom;
            send_text(s);
            if ($urandom_range(7) == 0)
               send_request(tnpe_pkg::KIND_UNUSED, $urandom, $urandom);
            end_and_read($urandom_range(3) == 0);
         end
         wait_drained();
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// File: sim.f
hdl/tnpe_pkg.sv
hdl/tnpe_front.sv
hdl/tnpe_back.sv
hdl/tag_name_path_encoder_unit.sv
tb/sv/tb.sv
